### hdl/amwd_pkg.sv
// ----------------------------------------------------------------------------
// Motion window detector package
// Widths, register indexes, the cell control group and small helper
// functions shared by the detector modules.
// ----------------------------------------------------------------------------
package amwd_pkg;

    // Number of qualify bits held in the window (2 to 64).
    localparam int WINDOW_LEN = 16;

    localparam int SAMPLE_W  = 16;
    localparam int THRESH_W  = 16;
    localparam int NOISE_W   = 18;
    localparam int NEED_W    = 5;
    localparam int DIFF_W    = 16;
    localparam int SUM_W     = 18;
    localparam int COUNT_W   = 5;
    localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
    localparam int CMP_W     = (CNT_W > NEED_W) ? CNT_W : NEED_W;

    localparam int IN_TDATA_W  = 3 * SAMPLE_W;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_THRESH_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESH_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESH_Z    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NEED_COUNT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_LEVEL = 3'd4;

    // Control seen by every cell of the window in one cycle.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Absolute difference of two signed samples; always fits in 16 bits.
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] d;
        logic signed [SAMPLE_W:0] n;
        d = (SAMPLE_W+1)'(a) - (SAMPLE_W+1)'(b);
        n = -d;
        return d[SAMPLE_W] ? n[DIFF_W-1:0] : d[DIFF_W-1:0];
    endfunction

    // Required count: zero acts as one, values above the window are capped.
    function automatic logic [CMP_W-1:0] need_cap(input logic [NEED_W-1:0] n);
        logic [CMP_W-1:0] r;
        if (n == '0)
            r = CMP_W'(1);
        else if (CMP_W'(n) > CMP_W'(WINDOW_LEN))
            r = CMP_W'(WINDOW_LEN);
        else
            r = CMP_W'(n);
        return r;
    endfunction

endpackage

### hdl/amwd_qual.sv
// ----------------------------------------------------------------------------
// Sample qualifier
// Keeps the previous sample, forms the per-axis absolute differences and
// registers the qualify decision for the window stage.
// ----------------------------------------------------------------------------
module amwd_qual (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic signed [amwd_pkg::SAMPLE_W-1:0]  sample_x,
    input  logic signed [amwd_pkg::SAMPLE_W-1:0]  sample_y,
    input  logic signed [amwd_pkg::SAMPLE_W-1:0]  sample_z,
    input  logic        [amwd_pkg::THRESH_W-1:0]  thresh_x,
    input  logic        [amwd_pkg::THRESH_W-1:0]  thresh_y,
    input  logic        [amwd_pkg::THRESH_W-1:0]  thresh_z,
    input  logic        [amwd_pkg::NOISE_W-1:0]   noise_level,
    output logic                                  qual
);
    import amwd_pkg::*;

    logic signed [SAMPLE_W-1:0] prev_x_reg;
    logic signed [SAMPLE_W-1:0] prev_y_reg;
    logic signed [SAMPLE_W-1:0] prev_z_reg;
    logic                       qual_reg;
    logic                       qual_next;
    logic [DIFF_W-1:0]          dx;
    logic [DIFF_W-1:0]          dy;
    logic [DIFF_W-1:0]          dz;
    logic [SUM_W-1:0]           sum;

    always_comb
    begin
        dx  = abs_diff(sample_x, prev_x_reg);
        dy  = abs_diff(sample_y, prev_y_reg);
        dz  = abs_diff(sample_z, prev_z_reg);
        sum = SUM_W'(dx) + SUM_W'(dy) + SUM_W'(dz);
        qual_next = (sum > noise_level) && (dx >= thresh_x) &&
                    (dy >= thresh_y) && (dz >= thresh_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
        end
        else if (load)
        begin
            prev_x_reg <= sample_x;
            prev_y_reg <= sample_y;
            prev_z_reg <= sample_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            qual_reg <= qual_next;
        end
    end

    assign qual = qual_reg;

endmodule

### hdl/amwd_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one qualify bit and hands it to the next cell on every step.
// ----------------------------------------------------------------------------
module amwd_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  amwd_pkg::cell_ctrl_t  ctrl,
    input  logic                  din,
    output logic                  q
);
    import amwd_pkg::*;

    logic q_reg;
    logic q_next;

    always_comb
    begin
        if (ctrl.clear)
            q_next = 1'b0;
        else if (ctrl.shift)
            q_next = din;
        else
            q_next = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### hdl/amwd_window.sv
// ----------------------------------------------------------------------------
// Qualify window
// A row of cells carrying the last qualify bits, with the running count
// and the fire decision.
// ----------------------------------------------------------------------------
module amwd_window (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic                               qual,
    input  logic [amwd_pkg::NEED_W-1:0]        need_count,
    output logic                               fired,
    output logic [amwd_pkg::CNT_W-1:0]         win_count
);
    import amwd_pkg::*;

    logic [WINDOW_LEN-1:0] flags;
    logic [WINDOW_LEN-1:0] cell_din;
    cell_ctrl_t            ctrl;
    logic [CNT_W-1:0]      hit_reg;
    logic [CNT_W-1:0]      hit_next;
    logic [CNT_W-1:0]      hit_step;
    logic                  fire;

    // The oldest bit sits in the last cell. Before the window has filled,
    // that cell still holds a cleared bit, so nothing is taken off early.
    assign hit_step = hit_reg - CNT_W'(flags[WINDOW_LEN-1]) + CNT_W'(qual);
    assign fire     = CMP_W'(hit_step) >= need_cap(need_count);

    assign ctrl.shift = step;
    assign ctrl.clear = step && fire;

    assign cell_din = {flags[WINDOW_LEN-2:0], qual};

    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        amwd_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .din   (cell_din[i]),
            .q     (flags[i])
        );
    end

    always_comb
    begin
        if (step)
            hit_next = fire ? '0 : hit_step;
        else
            hit_next = hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign fired     = fire;
    assign win_count = hit_step;

    a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags) == 32'(hit_reg))
        else $error("window count does not match the stored bits");

    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && fire |=> hit_reg == '0 && flags == '0)
        else $error("window not cleared after a fire");

    // Right after a step the count is below the required count, as long as
    // the required count has not been rewritten since.
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        $past(step) && $stable(need_count) |-> CMP_W'(hit_reg) < need_cap(need_count))
        else $error("window count reached the required count without a fire");

endmodule

### hdl/accel_motion_window_detector.sv
// ----------------------------------------------------------------------------
// Acceleration motion window detector
// Qualifies three-axis acceleration samples against per-axis thresholds and
// a noise level, and fires when enough qualifying samples fall in a window.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock cycle while the output side is
// not stalled and returns one result beat per sample, in order. A sample
// passes through the first and the second stage: the first stage compares
// the sample with the previous one and registers the qualify decision, the
// second stage shifts that decision into the row of window cells, updates
// the running count and loads the output register. Both stages move
// together whenever the output side is not stalled; the input side keeps
// accepting while a result waits on the output as long as the first stage
// has room. The window is WINDOW_LEN cells long (package constant).
// Thresholds, the required count and the noise level are written through
// the APB port; the user must write them only while no sample is in
// flight, as the block itself does not enforce this. Register i sits at
// byte address 4*i.
module accel_motion_window_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Sample stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata: sample_x [15:0], sample_y [31:16], sample_z [47:32]
    input  logic [amwd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata: fired [0], window_count [5:1], zero [7:6]
    output logic [amwd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [amwd_pkg::ADDR_W-1:0]          paddr,
    input  logic [amwd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [amwd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import amwd_pkg::*;

    // Configuration registers.
    logic [THRESH_W-1:0]  thresh_x_reg;
    logic [THRESH_W-1:0]  thresh_y_reg;
    logic [THRESH_W-1:0]  thresh_z_reg;
    logic [NEED_W-1:0]    need_count_reg;
    logic [NOISE_W-1:0]   noise_level_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    // Pipeline control and output register.
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_fired_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 accept;
    logic                 s2_ready;
    logic                 step;
    logic                 qual;
    logic                 fired;
    logic [CNT_W-1:0]     win_count;

    // ---------------------------------------------------------------- APB
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_x_reg    <= '0;
            thresh_y_reg    <= '0;
            thresh_z_reg    <= '0;
            need_count_reg  <= NEED_W'(1);
            noise_level_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_THRESH_X:    thresh_x_reg    <= pwdata[THRESH_W-1:0];
                REG_THRESH_Y:    thresh_y_reg    <= pwdata[THRESH_W-1:0];
                REG_THRESH_Z:    thresh_z_reg    <= pwdata[THRESH_W-1:0];
                REG_NEED_COUNT:  need_count_reg  <= pwdata[NEED_W-1:0];
                REG_NOISE_LEVEL: noise_level_reg <= pwdata[NOISE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Reads return the register zero-extended; unused addresses read zero.
    always_comb
    begin
        case (reg_idx)
            REG_THRESH_X:    prdata = CFG_DATA_W'(thresh_x_reg);
            REG_THRESH_Y:    prdata = CFG_DATA_W'(thresh_y_reg);
            REG_THRESH_Z:    prdata = CFG_DATA_W'(thresh_z_reg);
            REG_NEED_COUNT:  prdata = CFG_DATA_W'(need_count_reg);
            REG_NOISE_LEVEL: prdata = CFG_DATA_W'(noise_level_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------ beat handshake
    // The second stage advances whenever the output register is empty or
    // being drained this cycle; the first stage takes a new beat whenever
    // it is empty or handing its decision on.
    assign s2_ready = !out_valid_reg || m_tready;
    assign step     = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------- first stage
    amwd_qual u_qual (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .sample_x    (s_tdata[SAMPLE_W-1:0]),
        .sample_y    (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .sample_z    (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .thresh_x    (thresh_x_reg),
        .thresh_y    (thresh_y_reg),
        .thresh_z    (thresh_z_reg),
        .noise_level (noise_level_reg),
        .qual        (qual)
    );

    // --------------------------------------------------- second stage
    amwd_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .qual       (qual),
        .need_count (need_count_reg),
        .fired      (fired),
        .win_count  (win_count)
    );

    // The reported count is the low five bits of the count before clearing.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_fired_reg <= fired;
            out_count_reg <= COUNT_W'(win_count);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - COUNT_W - 1)'(0), out_count_reg, out_fired_reg};

endmodule
